// File: rtl/pse_pkg.sv
// Shared types, microcode control word and microcode table for the polynomial evaluator.
package pse_pkg;

    localparam int TERM_COUNT_DEF = 16;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_ADD   = 2'd1,
        OP_EVAL  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_WRITE   = 3'd1,
        ST_ADD_RD  = 3'd2,
        ST_ADD_WR  = 3'd3,
        ST_NULL    = 3'd4,
        ST_EV_INIT = 3'd5,
        ST_EV_LOOP = 3'd6
    } t_step;

    typedef enum logic [1:0] {
        RD_IDX  = 2'd0,
        RD_TOP  = 2'd1,
        RD_DOWN = 2'd2
    } t_rd_src;

    typedef enum logic {
        WR_CV  = 1'b0,
        WR_SUM = 1'b1
    } t_wr_src;

    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_WRITE = 2'd1,
        RES_ADD   = 2'd2,
        RES_MAC   = 2'd3
    } t_res_sel;

    typedef enum logic [1:0] {
        EM_NONE = 2'd0,
        EM_NOW  = 2'd1,
        EM_LAST = 2'd2
    } t_emit;

    typedef enum logic [1:0] {
        SEQ_GOTO     = 2'd0,
        SEQ_DISPATCH = 2'd1,
        SEQ_LOOP     = 2'd2
    } t_seq;

    typedef struct packed {
        logic     busy;
        logic     rd_en;
        t_rd_src  rd_src;
        logic     wr_en;
        t_wr_src  wr_src;
        logic     cnt_load;
        logic     cnt_dec;
        logic     acc_clr;
        logic     acc_mac;
        t_emit    emit;
        t_res_sel res_sel;
        t_seq     seq;
        t_step    target;
    } t_uword;

    // Microcode ROM: one control word per step
    function automatic t_uword f_ucode(t_step s);
        t_uword w;
        w = '0;
        w.busy   = 1'b1;
        w.seq    = SEQ_GOTO;
        w.target = ST_IDLE;
        case (s)
            ST_IDLE: begin
                w.busy = 1'b0;
                w.seq  = SEQ_DISPATCH;
            end
            ST_WRITE: begin
                w.wr_en   = 1'b1;
                w.wr_src  = WR_CV;
                w.emit    = EM_NOW;
                w.res_sel = RES_WRITE;
            end
            ST_ADD_RD: begin
                w.rd_en  = 1'b1;
                w.rd_src = RD_IDX;
                w.target = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                w.wr_en   = 1'b1;
                w.wr_src  = WR_SUM;
                w.emit    = EM_NOW;
                w.res_sel = RES_ADD;
            end
            ST_NULL: begin
                w.emit    = EM_NOW;
                w.res_sel = RES_ZERO;
            end
            ST_EV_INIT: begin
                w.rd_en    = 1'b1;
                w.rd_src   = RD_TOP;
                w.cnt_load = 1'b1;
                w.acc_clr  = 1'b1;
                w.target   = ST_EV_LOOP;
            end
            ST_EV_LOOP: begin
                w.rd_en   = 1'b1;
                w.rd_src  = RD_DOWN;
                w.cnt_dec = 1'b1;
                w.acc_mac = 1'b1;
                w.emit    = EM_LAST;
                w.res_sel = RES_MAC;
                w.seq     = SEQ_LOOP;
                w.target  = ST_IDLE;
            end
            default: begin
                w.seq    = SEQ_GOTO;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/pse_seq.sv
// Microcode sequencer: step counter, dispatch on operation and loop jump.
module pse_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_operation,
    input  logic            i_cnt_zero,
    output pse_pkg::t_uword o_uword,
    output logic            o_busy
);
    import pse_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_uword;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // next step
    always_comb begin
        n_step = r_step;
        case (w_uword.seq)
            SEQ_GOTO: begin
                n_step = w_uword.target;
            end
            SEQ_DISPATCH: begin
                if (i_start) begin
                    case (t_op'(i_operation))
                        OP_WRITE: n_step = ST_WRITE;
                        OP_ADD:   n_step = ST_ADD_RD;
                        OP_EVAL:  n_step = ST_EV_INIT;
                        default:  n_step = ST_NULL;
                    endcase
                end
            end
            SEQ_LOOP: begin
                if (i_cnt_zero) begin
                    n_step = w_uword.target;
                end
            end
            default: begin
                n_step = ST_IDLE;
            end
        endcase
    end

    // control word
    always_comb begin
        w_uword = f_ucode(r_step);
        o_uword = w_uword;
        o_busy  = w_uword.busy;
    end

endmodule

// File: rtl/polynomial_store_and_evaluate_top.sv
// Evaluate runs on the single multiply-add unit, fed one coefficient per cycle from the
// store's read port. A transaction is taken only while busy is low; for write and add
// the next transaction is taken while a result shows.
// Reset (synchronous, active low) idles the sequencer and marks every coefficient zero.
// Results cannot be stalled by the receiver.
module polynomial_store_and_evaluate_top #(
    parameter int TERM_COUNT = pse_pkg::TERM_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_exponent_index,
    input  logic [31:0] i_coefficient_value,
    input  logic [31:0] i_x_value,
    output logic        o_result_valid,
    output logic [31:0] o_poly_value,
    output logic        o_saturated
);
    import pse_pkg::*;

    localparam int AW = (TERM_COUNT > 1) ? $clog2(TERM_COUNT) : 1;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    // saturating add, overflow flag in bit 32 of the return value
    function automatic logic [32:0] f_sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        logic        ovf;
        s   = {a[31], a} + {b[31], b};
        ovf = (s[32] != s[31]);
        if (ovf) begin
            return {1'b1, (s[32] ? Q_MIN : Q_MAX)};
        end
        return {1'b0, s[31:0]};
    endfunction

    t_uword w_uw;
    logic   w_busy;

    logic [3:0]    r_idx;
    logic [31:0]   r_cv;
    logic [31:0]   r_x;

    logic [31:0]   r_mem [TERM_COUNT];
    logic [TERM_COUNT-1:0] r_vld;
    logic [31:0]   r_rd_data;
    logic          r_rd_vld;

    logic [AW-1:0] r_cnt;
    logic [31:0]   r_acc;
    logic          r_sat;

    logic          r_result_valid;
    logic [31:0]   r_poly_value;
    logic          r_saturated;
    logic          n_result_valid;
    logic [31:0]   n_poly_value;
    logic          n_saturated;

    logic          w_accept;
    logic          w_idx_ok;
    logic          w_cnt_zero;
    logic [AW-1:0] w_idx_addr;
    logic [AW-1:0] w_rd_addr;
    logic          w_rd_en;
    logic [31:0]   w_coef;
    logic [32:0]   w_upd;
    logic [31:0]   w_wr_data;

    logic signed [63:0] w_prod;
    logic signed [63:0] w_prod_rnd;
    logic [47:0]   w_mul_q;
    logic          w_mul_ovf;
    logic [31:0]   w_mul_sat;
    logic [32:0]   w_mac;

    pse_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_cnt_zero  (w_cnt_zero),
        .o_uword     (w_uw),
        .o_busy      (w_busy)
    );

    assign busy       = w_busy;
    assign w_accept   = start && !w_busy;
    assign w_idx_ok   = (32'(r_idx) < 32'(TERM_COUNT));
    assign w_cnt_zero = (r_cnt == '0);
    assign w_idx_addr = AW'(r_idx);

    // read address and enable; never read outside the store
    always_comb begin
        w_rd_addr = w_idx_addr;
        w_rd_en   = 1'b0;
        case (w_uw.rd_src)
            RD_IDX: begin
                w_rd_addr = w_idx_addr;
                w_rd_en   = w_uw.rd_en && w_idx_ok;
            end
            RD_TOP: begin
                w_rd_addr = AW'(TERM_COUNT - 1);
                w_rd_en   = w_uw.rd_en;
            end
            RD_DOWN: begin
                w_rd_addr = r_cnt - 1'b1;
                w_rd_en   = w_uw.rd_en && !w_cnt_zero;
            end
            default: begin
                w_rd_addr = w_idx_addr;
                w_rd_en   = 1'b0;
            end
        endcase
    end

    // entries never written read as zero
    assign w_coef    = r_rd_vld ? r_rd_data : 32'd0;
    assign w_upd     = f_sat_add(w_coef, r_cv);
    assign w_wr_data = (w_uw.wr_src == WR_SUM) ? w_upd[31:0] : r_cv;

    // Horner step: sat(sat(acc * x) + coef), product rounded half up
    assign w_prod     = $signed(r_acc) * $signed(r_x);
    assign w_prod_rnd = w_prod + 64'sd32768;
    assign w_mul_q    = w_prod_rnd[63:16];
    assign w_mul_ovf  = !((&w_mul_q[47:31]) || !(|w_mul_q[47:31]));
    assign w_mul_sat  = w_mul_ovf ? (w_mul_q[47] ? Q_MIN : Q_MAX) : w_mul_q[31:0];
    assign w_mac      = f_sat_add(w_mul_sat, w_coef);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx <= i_exponent_index;
            r_cv  <= i_coefficient_value;
            r_x   <= i_x_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uw.wr_en && w_idx_ok) begin
            r_mem[w_idx_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_uw.wr_en && w_idx_ok) begin
                r_vld[w_idx_addr] <= 1'b1;
            end
            if (w_rd_en) begin
                r_rd_vld <= r_vld[w_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uw.cnt_load) begin
            r_cnt <= AW'(TERM_COUNT - 1);
        end else if (w_uw.cnt_dec) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (w_uw.acc_clr) begin
            r_acc <= 32'd0;
            r_sat <= 1'b0;
        end else if (w_uw.acc_mac) begin
            r_acc <= w_mac[31:0];
            r_sat <= r_sat | w_mul_ovf | w_mac[32];
        end
    end

    // result register
    always_comb begin
        n_result_valid = (w_uw.emit == EM_NOW) || ((w_uw.emit == EM_LAST) && w_cnt_zero);
        n_poly_value   = 32'd0;
        n_saturated    = 1'b0;
        case (w_uw.res_sel)
            RES_ZERO: begin
                n_poly_value = 32'd0;
                n_saturated  = 1'b0;
            end
            RES_WRITE: begin
                n_poly_value = w_idx_ok ? r_cv : 32'd0;
                n_saturated  = 1'b0;
            end
            RES_ADD: begin
                n_poly_value = w_idx_ok ? w_upd[31:0] : 32'd0;
                n_saturated  = w_idx_ok && w_upd[32];
            end
            RES_MAC: begin
                n_poly_value = w_mac[31:0];
                n_saturated  = r_sat | w_mul_ovf | w_mac[32];
            end
            default: begin
                n_poly_value = 32'd0;
                n_saturated  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= n_result_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_result_valid) begin
            r_poly_value <= n_poly_value;
            r_saturated  <= n_saturated;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_poly_value   = r_poly_value;
    assign o_saturated    = r_saturated;

endmodule

// File: verif/pse_result_checker.sv
// Checker for the polynomial store: mirrors the coefficient store and compares every result.
`timescale 1ns / 100ps

module pse_result_checker #(
    parameter int TERM_COUNT = pse_pkg::TERM_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_exponent_index,
    input  logic [31:0] i_coefficient_value,
    input  logic [31:0] i_x_value,
    input  logic        o_result_valid,
    input  logic [31:0] o_poly_value,
    input  logic        o_saturated,
    output int          o_fail_count,
    output int          o_pending
);

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] value;
        logic               sat;
    } t_poly_result;

    t_poly_result       awaited_results[$];
    logic signed [31:0] coeff_mirror [TERM_COUNT];
    int                 fail_total = 0;

    function automatic logic signed [31:0] q_clip(input longint v, inout logic hit);
        if (v > Q_HI) begin
            hit = 1'b1;
            return Q_HI[31:0];
        end
        if (v < Q_LO) begin
            hit = 1'b1;
            return Q_LO[31:0];
        end
        return v[31:0];
    endfunction

    // Q16.16 product, round half up, then clip
    function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 inout logic hit);
        longint prod;
        prod = longint'(a) * longint'(b);
        return q_clip((prod + 64'sd32768) >>> 16, hit);
    endfunction

    function automatic logic signed [31:0] q_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 inout logic hit);
        return q_clip(longint'(a) + longint'(b), hit);
    endfunction

    // Applies one operation to the mirror and returns the result it must produce
    function automatic t_poly_result predict_poly_op(input logic [1:0]  op,
                                                     input logic [3:0]  idx,
                                                     input logic [31:0] coeff,
                                                     input logic [31:0] x);
        t_poly_result       res;
        logic signed [31:0] acc;
        res = '0;
        acc = '0;
        case (op)
            pse_pkg::OP_WRITE: begin
                if (idx < TERM_COUNT) begin
                    coeff_mirror[idx] = coeff;
                    res.value = coeff;
                end
            end
            pse_pkg::OP_ADD: begin
                if (idx < TERM_COUNT) begin
                    coeff_mirror[idx] = q_add(coeff_mirror[idx], coeff, res.sat);
                    res.value = coeff_mirror[idx];
                end
            end
            pse_pkg::OP_EVAL: begin
                for (int i = TERM_COUNT - 1; i >= 0; i--) begin
                    acc = q_mul(acc, x, res.sat);
                    acc = q_add(acc, coeff_mirror[i], res.sat);
                end
                res.value = acc;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_poly_result due;
        if (!i_rst_n) begin
            for (int i = 0; i < TERM_COUNT; i++) begin
                coeff_mirror[i] = '0;
            end
            awaited_results.delete();
        end else begin
            // a result can never belong to a transaction taken at this same edge
            if (o_result_valid) begin
                if (awaited_results.size() == 0) begin
                    if (fail_total < 10)
                        $display("%0t: unexpected result poly_value %h saturated %0b",
                                 $realtime, o_poly_value, o_saturated);
                    fail_total++;
                end else begin
                    due = awaited_results.pop_front();
                    if (due.value !== o_poly_value || due.sat !== o_saturated) begin
                        if (fail_total < 10)
                            $display({"%0t: mismatch poly_value exp %h got %h, ",
                                      "saturated exp %0b got %0b"}, $realtime,
                                     due.value, o_poly_value, due.sat, o_saturated);
                        fail_total++;
                    end
                end
            end
            if (start && !busy)
                awaited_results.push_back(predict_poly_op(i_operation, i_exponent_index,
                                                          i_coefficient_value, i_x_value));
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: verif/polynomial_store_and_evaluate_top_tb.sv
// Testbench top for the polynomial store and evaluator: reset, stimulus and verdict.
`timescale 1ns / 100ps

module polynomial_store_and_evaluate_top_tb;

    import pse_pkg::*;

    localparam int          TERM_COUNT   = TERM_COUNT_DEF;
    localparam int          RESET_CYCLES = 7;
    localparam int          ITEM_TARGET  = 1300;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [31:0] Q_ONE        = 32'h0001_0000;
    localparam logic [31:0] Q_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN        = 32'h8000_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_operation = '0;
    logic [3:0]  i_exponent_index = '0;
    logic [31:0] i_coefficient_value = '0;
    logic [31:0] i_x_value = '0;
    logic        o_result_valid;
    logic [31:0] o_poly_value;
    logic        o_saturated;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int items_sent = 0;
    int burst_left = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    polynomial_store_and_evaluate_top #(
        .TERM_COUNT(TERM_COUNT)
    ) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_operation         (i_operation),
        .i_exponent_index    (i_exponent_index),
        .i_coefficient_value (i_coefficient_value),
        .i_x_value           (i_x_value),
        .o_result_valid      (o_result_valid),
        .o_poly_value        (o_poly_value),
        .o_saturated         (o_saturated)
    );

    pse_result_checker #(
        .TERM_COUNT(TERM_COUNT)
    ) u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_operation         (i_operation),
        .i_exponent_index    (i_exponent_index),
        .i_coefficient_value (i_coefficient_value),
        .i_x_value           (i_x_value),
        .o_result_valid      (o_result_valid),
        .o_poly_value        (o_poly_value),
        .o_saturated         (o_saturated),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    function automatic logic [31:0] pick_coeff();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return 32'hFFFF_FFFF;
                    default: return '0;
                endcase
            end
            1, 2:    return $urandom;
            default: return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
        endcase
    endfunction

    // mostly |x| <= 2.0 so long polynomials do not always clip
    function automatic logic [31:0] pick_x();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return Q_ONE;
                    3:       return -Q_ONE;
                    default: return '0;
                endcase
            end
            1, 2:       return $urandom;
            3, 4, 5:    return 32'($urandom_range(0, 32'h0002_0000)) - Q_ONE;
            default:    return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        endcase
    endfunction

    // Presents one transaction and returns at the edge that takes it
    task automatic send_op(input logic [1:0] op, input logic [3:0] idx,
                           input logic [31:0] coeff, input logic [31:0] x);
        start               <= 1'b1;
        i_operation         <= op;
        i_exponent_index    <= idx;
        i_coefficient_value <= coeff;
        i_x_value           <= x;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic pause_random();
        int gap;
        int r;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(0, 99) < 3)
                burst_left = $urandom_range(20, 60);
            r = $urandom_range(0, 99);
            if (r < 45)
                gap = 0;
            else if (r < 80)
                gap = $urandom_range(1, 3);
            else if (r < 96)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 60);
        end
        if ($urandom_range(0, 199) == 0) begin
            wait_drained();
        end else if (gap > 0) begin
            // junk on the fields while start is low
            start               <= 1'b0;
            i_operation         <= 2'($urandom);
            i_exponent_index    <= 4'($urandom);
            i_coefficient_value <= $urandom;
            i_x_value           <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int  degree;
        int  r;
        bit  drained_once;
        logic [1:0] op;
        drained_once = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, clipping in both directions, rounding ties, unused code
        send_op(OP_EVAL, 4'd0, 32'd0, Q_MAX);
        send_op(OP_WRITE, 4'd0, Q_MAX, 32'd0);
        send_op(OP_WRITE, 4'd15, Q_MIN, 32'd0);
        send_op(OP_ADD, 4'd0, 32'd1, 32'd0);
        send_op(OP_ADD, 4'd15, 32'hFFFF_FFFF, 32'd0);
        send_op(OP_EVAL, 4'd0, 32'd0, 32'd0);
        send_op(OP_EVAL, 4'd0, 32'd0, Q_ONE);
        send_op(OP_EVAL, 4'd15, Q_MAX, Q_MAX);
        send_op(OP_EVAL, 4'd0, Q_MIN, Q_MIN);
        send_op(OP_UNUSED, 4'd15, Q_MIN, Q_MAX);
        send_op(OP_UNUSED, 4'd0, 32'd0, 32'd0);
        send_op(OP_WRITE, 4'd0, 32'd0, Q_MAX);
        send_op(OP_WRITE, 4'd15, 32'd0, Q_MIN);
        send_op(OP_WRITE, 4'd1, 32'h0000_8000, 32'd0);
        send_op(OP_EVAL, 4'd0, 32'd0, 32'd1);
        send_op(OP_EVAL, 4'd0, 32'd0, 32'hFFFF_FFFF);
        send_op(OP_ADD, 4'd1, 32'hFFFF_8000, 32'd0);
        send_op(OP_ADD, 4'd7, Q_MIN, 32'd0);
        send_op(OP_ADD, 4'd7, Q_MIN, 32'd0);
        send_op(OP_WRITE, 4'd7, Q_MAX, Q_MIN);
        send_op(OP_ADD, 4'd7, Q_MAX, 32'd0);
        send_op(OP_WRITE, 4'd7, 32'd0, 32'd0);
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 3) begin
                // rebuild the polynomial at a random degree, then evaluate it
                degree = $urandom_range(0, TERM_COUNT - 1);
                for (int k = 0; k < TERM_COUNT; k++) begin
                    send_op(OP_WRITE, k[3:0], (k <= degree) ? pick_coeff() : 32'd0, $urandom);
                    pause_random();
                end
                repeat ($urandom_range(1, 4)) begin
                    send_op(OP_EVAL, 4'($urandom), $urandom, pick_x());
                    pause_random();
                end
            end else begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    op = OP_WRITE;
                else if (r < 60)
                    op = OP_ADD;
                else if (r < 95)
                    op = OP_EVAL;
                else
                    op = OP_UNUSED;
                send_op(op, ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom),
                        pick_coeff(), pick_x());
                pause_random();
            end
            if (!drained_once && items_sent >= ITEM_TARGET / 2) begin
                wait_drained();
                drained_once = 1'b1;
            end
        end

        wait_drained();
        repeat (TERM_COUNT + 4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/pse_pkg.sv
rtl/pse_seq.sv
rtl/polynomial_store_and_evaluate_top.sv
verif/pse_result_checker.sv
verif/polynomial_store_and_evaluate_top_tb.sv
